FILE: hdl/bsfn_pkg.sv
// Shared constants, types and bit-search helpers for the bit set block.
package bsfn_pkg;

  localparam int NBITS       = 256;
  localparam int WORD_BITS   = 64;
  localparam int NWORDS      = NBITS / WORD_BITS;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int WORD_IDX_W  = $clog2(NWORDS);
  localparam int ELEM_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int MODE_W      = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET       = 4'd0,
    MODE_CLEAR     = 4'd1,
    MODE_TEST      = 4'd2,
    MODE_FIRST     = 4'd3,
    MODE_NEXT      = 4'd4,
    MODE_LAST      = 4'd5,
    MODE_HAS_NEXT  = 4'd6,
    MODE_CLEAR_ALL = 4'd7,
    MODE_COUNT     = 4'd8
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_step;
    logic load_out;
  } bsfn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_is_find;
    logic scan_done;
  } bsfn_status_t;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [BIT_IDX_W-1:0] lsb_index(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [BIT_IDX_W-1:0] msb_index(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        r = BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/bsfn_ctrl.sv
// Controller state machine that sequences request, execute, word scan and result transfer.
module bsfn_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  bsfn_pkg::bsfn_status_t status_i,
  output bsfn_pkg::bsfn_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.req_is_find ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result only appears after the finish state has handed it over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result valid rose outside the finish state");

  // An accepted request always moves the controller into execute or scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_EXEC || state_q == ST_SCAN))
    else $error("accepted request did not start work");

endmodule

FILE: hdl/bsfn_dpath.sv
// Datapath: member word store, member count, word scanner and result registers.
module bsfn_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bsfn_pkg::MODE_W-1:0]         mode_i,
  input  logic [bsfn_pkg::ELEM_W-1:0]         element_i,
  input  bsfn_pkg::bsfn_cmd_t                 cmd_i,
  output bsfn_pkg::bsfn_status_t              status_o,
  output logic                                flag_o,
  output logic [bsfn_pkg::ELEM_W-1:0]         position_o,
  output logic [bsfn_pkg::COUNT_W-1:0]        member_count_o
);

  localparam int WIW = bsfn_pkg::WORD_IDX_W;
  localparam int BIW = bsfn_pkg::BIT_IDX_W;
  localparam int EW  = bsfn_pkg::ELEM_W;
  localparam int WB  = bsfn_pkg::WORD_BITS;
  localparam int CW  = bsfn_pkg::COUNT_W;
  localparam logic [WIW-1:0] LAST_WORD = WIW'(bsfn_pkg::NWORDS - 1);

  logic [WB-1:0]   words_q [bsfn_pkg::NWORDS];
  logic [CW-1:0]   count_q;
  bsfn_pkg::mode_e mode_q;
  logic [EW:0]     from_q;
  logic [WIW-1:0]  widx_q;
  logic            down_q;
  logic            res_flag_q;
  logic [EW-1:0]   res_pos_q;

  bsfn_pkg::mode_e req_mode;
  logic [EW:0]     next_from;
  logic [WB-1:0]   cur_word;
  logic [WB-1:0]   scan_mask;
  logic [WB-1:0]   masked;
  logic            hit;
  logic            last_word;
  logic [BIW-1:0]  hit_bit;
  logic            cur_bit;

  assign req_mode  = bsfn_pkg::mode_e'(mode_i);
  assign next_from = {1'b0, element_i} + (EW + 1)'(1);

  assign status_o.req_is_find = (req_mode == bsfn_pkg::MODE_FIRST) ||
                                (req_mode == bsfn_pkg::MODE_NEXT) ||
                                (req_mode == bsfn_pkg::MODE_LAST) ||
                                (req_mode == bsfn_pkg::MODE_HAS_NEXT);

  // Only the word holding the start index needs the bits below it masked off.
  assign cur_word  = words_q[widx_q];
  assign scan_mask = (widx_q == from_q[EW-1 -: WIW]) ? ({WB{1'b1}} << from_q[BIW-1:0])
                                                     : {WB{1'b1}};
  assign masked    = cur_word & scan_mask;
  assign hit       = (|masked) && !from_q[EW];
  assign last_word = down_q ? (widx_q == '0) : (widx_q == LAST_WORD);
  assign hit_bit   = down_q ? bsfn_pkg::msb_index(masked) : bsfn_pkg::lsb_index(masked);
  assign cur_bit   = cur_word[from_q[BIW-1:0]];

  assign status_o.scan_done = hit || last_word || from_q[EW];

  // Request capture, scan walk, result capture and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= req_mode;
      down_q <= (req_mode == bsfn_pkg::MODE_LAST);
      case (req_mode)
        bsfn_pkg::MODE_FIRST, bsfn_pkg::MODE_LAST: begin
          from_q <= '0;
          widx_q <= (req_mode == bsfn_pkg::MODE_LAST) ? LAST_WORD : '0;
        end
        bsfn_pkg::MODE_NEXT, bsfn_pkg::MODE_HAS_NEXT: begin
          from_q <= next_from;
          widx_q <= next_from[EW-1 -: WIW];
        end
        default: begin
          from_q <= {1'b0, element_i};
          widx_q <= element_i[EW-1 -: WIW];
        end
      endcase
    end else if (cmd_i.scan_step && !status_o.scan_done) begin
      widx_q <= down_q ? (widx_q - WIW'(1)) : (widx_q + WIW'(1));
    end

    if (cmd_i.scan_step && status_o.scan_done) begin
      res_flag_q <= hit;
      res_pos_q  <= (hit && mode_q != bsfn_pkg::MODE_HAS_NEXT) ? {widx_q, hit_bit} : '0;
    end else if (cmd_i.exec) begin
      res_flag_q <= (mode_q == bsfn_pkg::MODE_TEST) ? cur_bit : 1'b0;
      res_pos_q  <= '0;
    end

    if (cmd_i.load_out) begin
      flag_o     <= res_flag_q;
      position_o <= res_pos_q;
    end
  end

  // Member store and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bsfn_pkg::NWORDS; i++) begin
        words_q[i] <= '0;
      end
      count_q        <= '0;
      member_count_o <= '0;
    end else begin
      if (cmd_i.exec) begin
        case (mode_q)
          bsfn_pkg::MODE_SET: begin
            if (!cur_bit) begin
              words_q[widx_q][from_q[BIW-1:0]] <= 1'b1;
              count_q <= count_q + CW'(1);
            end
          end
          bsfn_pkg::MODE_CLEAR: begin
            if (cur_bit) begin
              words_q[widx_q][from_q[BIW-1:0]] <= 1'b0;
              count_q <= count_q - CW'(1);
            end
          end
          bsfn_pkg::MODE_CLEAR_ALL: begin
            for (int i = 0; i < bsfn_pkg::NWORDS; i++) begin
              words_q[i] <= '0;
            end
            count_q <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.load_out) begin
        member_count_o <= count_q;
      end
    end
  end

  // The count can never exceed the size of the set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bsfn_pkg::NBITS))
    else $error("member count out of range");

  // Clear-all leaves an empty count behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && mode_q == bsfn_pkg::MODE_CLEAR_ALL) |=> (count_q == '0))
    else $error("clear-all did not zero the count");

endmodule

FILE: hdl/bit_set_find_next_core.sv
// Top level of the bit set with set, clear, test, find, clear-all and count requests.
// Set, clear, test, clear-all and count pass through the execute and finish states.
// First, next, has-next and last scan one stored word per cycle until a hit, the last word
// or a start past the end, then pass through the finish state.
// One request is worked at a time; a finished result waits in the output register.
// rst_ni clears the member store, the count and all control state asynchronously.
module bit_set_find_next_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bsfn_pkg::MODE_W-1:0]        mode_i,
  input  logic [bsfn_pkg::ELEM_W-1:0]        element_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               flag_o,
  output logic [bsfn_pkg::ELEM_W-1:0]        position_o,
  output logic [bsfn_pkg::COUNT_W-1:0]       member_count_o
);

  bsfn_pkg::bsfn_cmd_t    cmd;
  bsfn_pkg::bsfn_status_t status;

  bsfn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bsfn_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .element_i      (element_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .flag_o         (flag_o),
    .position_o     (position_o),
    .member_count_o (member_count_o)
  );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for bit_set_find_next_core: queued requests, result scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned SEGMENTS       = 8;
  localparam int unsigned SEGMENT_LEN    = 220;
  localparam logic [bsfn_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [bsfn_pkg::MODE_W-1:0] MODE_UNUSED_HI = {bsfn_pkg::MODE_W{1'b1}};

  typedef struct {
    logic [bsfn_pkg::MODE_W-1:0] mode;
    logic [bsfn_pkg::ELEM_W-1:0] element;
    bit                          drain_first;
  } bitset_req_t;

  typedef struct {
    logic                         flag;
    logic [bsfn_pkg::ELEM_W-1:0]  position;
    logic [bsfn_pkg::COUNT_W-1:0] member_count;
  } bitset_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [bsfn_pkg::MODE_W-1:0]  mode_i = '0;
  logic [bsfn_pkg::ELEM_W-1:0]  element_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         flag_o;
  logic [bsfn_pkg::ELEM_W-1:0]  position_o;
  logic [bsfn_pkg::COUNT_W-1:0] member_count_o;

  bit [bsfn_pkg::NBITS-1:0]     member_bits;
  logic [bsfn_pkg::COUNT_W-1:0] member_total = '0;
  int unsigned                  peak_total;

  bitset_req_t    pending_reqs[$];
  bitset_result_t expected_results[$];

  int unsigned n_issued;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned idle_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned mode_hits[16];

  bit_set_find_next_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .element_i      (element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .flag_o         (flag_o),
    .position_o     (position_o),
    .member_count_o (member_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the shadow bit set and returns what the block must answer.
  function automatic bitset_result_t bitset_apply(input bitset_req_t r);
    bitset_result_t res;
    int             i;
    bit             hit;
    res = '{flag: 1'b0, position: '0, member_count: '0};
    hit = 1'b0;
    case (r.mode)
      bsfn_pkg::MODE_SET: begin
        if (!member_bits[r.element]) begin
          member_bits[r.element] = 1'b1;
          member_total = member_total + bsfn_pkg::COUNT_W'(1);
        end
      end
      bsfn_pkg::MODE_CLEAR: begin
        if (member_bits[r.element]) begin
          member_bits[r.element] = 1'b0;
          member_total = member_total - bsfn_pkg::COUNT_W'(1);
        end
      end
      bsfn_pkg::MODE_TEST: begin
        res.flag = member_bits[r.element];
      end
      bsfn_pkg::MODE_FIRST, bsfn_pkg::MODE_NEXT, bsfn_pkg::MODE_HAS_NEXT: begin
        i = (r.mode == bsfn_pkg::MODE_FIRST) ? 0 : int'(r.element) + 1;
        while (i < bsfn_pkg::NBITS && !hit) begin
          if (member_bits[i]) begin
            hit = 1'b1;
            res.position = bsfn_pkg::ELEM_W'(i);
          end
          i++;
        end
        res.flag = hit;
        // Has-next only reports whether something lies above, never where.
        if (r.mode == bsfn_pkg::MODE_HAS_NEXT) begin
          res.position = '0;
        end
      end
      bsfn_pkg::MODE_LAST: begin
        i = bsfn_pkg::NBITS - 1;
        while (i >= 0 && !hit) begin
          if (member_bits[i]) begin
            hit = 1'b1;
            res.position = bsfn_pkg::ELEM_W'(i);
          end
          i--;
        end
        res.flag = hit;
      end
      bsfn_pkg::MODE_CLEAR_ALL: begin
        member_bits  = '0;
        member_total = '0;
      end
      default: begin
      end
    endcase
    res.member_count = member_total;
    return res;
  endfunction

  task automatic queue_req(input logic [bsfn_pkg::MODE_W-1:0] m,
                           input logic [bsfn_pkg::ELEM_W-1:0] e,
                           input bit drain = 1'b0);
    bitset_req_t r;
    r.mode        = m;
    r.element     = e;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endtask

  // Word boundaries and the ends of the set are favored a quarter of the time.
  function automatic logic [bsfn_pkg::ELEM_W-1:0] pick_element();
    logic [bsfn_pkg::ELEM_W-1:0] edges[8];
    edges = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    if ($urandom_range(0, 3) == 0) begin
      return edges[$urandom_range(0, 7)];
    end
    return bsfn_pkg::ELEM_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [bsfn_pkg::MODE_W-1:0] pick_mode(input int unsigned set_w,
                                                            input int unsigned clear_w);
    int unsigned r;
    r = $urandom_range(0, set_w + clear_w + 59);
    if (r < set_w) return bsfn_pkg::MODE_SET;
    r = r - set_w;
    if (r < clear_w) return bsfn_pkg::MODE_CLEAR;
    r = r - clear_w;
    if (r < 10) return bsfn_pkg::MODE_TEST;
    if (r < 16) return bsfn_pkg::MODE_FIRST;
    if (r < 30) return bsfn_pkg::MODE_NEXT;
    if (r < 36) return bsfn_pkg::MODE_LAST;
    if (r < 46) return bsfn_pkg::MODE_HAS_NEXT;
    if (r < 52) return bsfn_pkg::MODE_COUNT;
    if (r < 54) return bsfn_pkg::MODE_CLEAR_ALL;
    return bsfn_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
  endfunction

  // Stimulus and end of run.
  initial begin
    int unsigned seg;
    int unsigned k;
    int unsigned set_w;
    int unsigned clear_w;
    int unsigned start;

    // Empty set, then both ends, word boundaries and the no-change cases.
    queue_req(bsfn_pkg::MODE_COUNT, 8'd0);
    queue_req(bsfn_pkg::MODE_FIRST, 8'd0);
    queue_req(bsfn_pkg::MODE_LAST, 8'd0);
    queue_req(bsfn_pkg::MODE_NEXT, 8'd0);
    queue_req(bsfn_pkg::MODE_HAS_NEXT, 8'd0);
    queue_req(bsfn_pkg::MODE_TEST, 8'd0);
    queue_req(bsfn_pkg::MODE_SET, 8'd0);
    queue_req(bsfn_pkg::MODE_SET, 8'd255);
    queue_req(bsfn_pkg::MODE_SET, 8'd0);
    queue_req(bsfn_pkg::MODE_TEST, 8'd255);
    queue_req(bsfn_pkg::MODE_TEST, 8'd1);
    queue_req(bsfn_pkg::MODE_FIRST, 8'd0);
    queue_req(bsfn_pkg::MODE_LAST, 8'd0);
    queue_req(bsfn_pkg::MODE_NEXT, 8'd0);
    queue_req(bsfn_pkg::MODE_NEXT, 8'd255);
    queue_req(bsfn_pkg::MODE_HAS_NEXT, 8'd254);
    queue_req(bsfn_pkg::MODE_HAS_NEXT, 8'd255);
    queue_req(bsfn_pkg::MODE_CLEAR, 8'd1);
    queue_req(bsfn_pkg::MODE_SET, 8'd64);
    queue_req(bsfn_pkg::MODE_NEXT, 8'd63);
    queue_req(bsfn_pkg::MODE_CLEAR, 8'd0);
    queue_req(MODE_UNUSED_LO, 8'd255);
    queue_req(MODE_UNUSED_HI, 8'd170);
    queue_req(bsfn_pkg::MODE_CLEAR_ALL, 8'd85);
    queue_req(bsfn_pkg::MODE_COUNT, 8'd0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      set_w   = $urandom_range(10, 50);
      clear_w = $urandom_range(5, 30);
      // Each segment starts only after the block has handed back everything so far.
      queue_req(pick_mode(set_w, clear_w), pick_element(), 1'b1);
      for (k = 1; k < SEGMENT_LEN; k++) begin
        queue_req(pick_mode(set_w, clear_w), pick_element());
      end
      if (seg == 2) begin
        // Fill the whole set from a random start so the count reaches its top value.
        start = $urandom_range(0, 255);
        for (k = 0; k < bsfn_pkg::NBITS; k++) begin
          queue_req(bsfn_pkg::MODE_SET, bsfn_pkg::ELEM_W'((start + k) % bsfn_pkg::NBITS));
          if (k % 37 == 0) begin
            queue_req(bsfn_pkg::MODE_NEXT, pick_element());
          end
        end
        queue_req(bsfn_pkg::MODE_COUNT, 8'd0);
        queue_req(bsfn_pkg::MODE_FIRST, 8'd0);
        queue_req(bsfn_pkg::MODE_LAST, 8'd0);
        queue_req(bsfn_pkg::MODE_HAS_NEXT, 8'd254);
        queue_req(bsfn_pkg::MODE_SET, 8'd17);
        queue_req(bsfn_pkg::MODE_CLEAR, 8'd0);
        queue_req(bsfn_pkg::MODE_CLEAR, 8'd255);
        queue_req(bsfn_pkg::MODE_FIRST, 8'd0);
        queue_req(bsfn_pkg::MODE_LAST, 8'd0);
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || n_accepted != n_issued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_errors++;
    end
    $display("Covered %0d requests (set %0d, clear %0d, finds %0d, unused modes seen), %0d results",
             n_accepted, mode_hits[bsfn_pkg::MODE_SET], mode_hits[bsfn_pkg::MODE_CLEAR],
             mode_hits[bsfn_pkg::MODE_FIRST] + mode_hits[bsfn_pkg::MODE_NEXT]
             + mode_hits[bsfn_pkg::MODE_LAST] + mode_hits[bsfn_pkg::MODE_HAS_NEXT],
             n_checked);
    $display("Peak membership reached %0d of %0d bits", peak_total, bsfn_pkg::NBITS);
    if (n_errors == 0) begin
      $display("bit_set_find_next_core verification clean");
    end else begin
      $display("bit_set_find_next_core verification failed");
    end
    $finish;
  end

  // Driver: a new request goes out only once the one on the bus has been transferred.
  always @(negedge clk_i) begin
    bitset_req_t r;
    if (rst_ni && !(in_valid_i && n_issued != n_accepted)) begin
      if (idle_left != 0) begin
        in_valid_i <= 1'b0;
        idle_left--;
      end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        idle_left = $urandom_range(0, 4);
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && expected_results.size() != 0)) begin
        r = pending_reqs.pop_front();
        mode_i     <= r.mode;
        element_i  <= r.element;
        in_valid_i <= 1'b1;
        n_issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check results against the oldest expectation, then predict new requests.
  always @(posedge clk_i) begin
    bitset_result_t want;
    bitset_req_t    r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (flag_o !== want.flag) begin
            $error("flag: expected %0d, actual %0d", want.flag, flag_o);
            n_errors++;
          end
          if (position_o !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position_o);
            n_errors++;
          end
          if (member_count_o !== want.member_count) begin
            $error("member_count: expected %0d, actual %0d", want.member_count,
                   member_count_o);
            n_errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        r.mode        = mode_i;
        r.element     = element_i;
        r.drain_first = 1'b0;
        expected_results.push_back(bitset_apply(r));
        mode_hits[mode_i]++;
        if (member_total > peak_total) begin
          peak_total = member_total;
        end
        n_accepted++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet_cycles);
        $display("bit_set_find_next_core verification failed");
        $finish;
      end
    end
  end

endmodule
